>>> hdl/owdm_pkg.sv
// owdm_pkg: shared types, constants and the quarter-wave sine table of the
// omni wheel drive mixer. No dependencies.
`timescale 1ns / 1ps

package owdm_pkg;

  localparam int unsigned WHEEL_COUNT    = 4;
  localparam int unsigned SINE_FRAC_BITS = 15;

  // field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned DIR_W    = 10;
  localparam int unsigned PCT_W    = 8;
  localparam int unsigned SET_W    = 9;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned SPEED_W  = 10;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // |speed| (0..256) times the Q1.8 gain, at most 130816
  localparam int unsigned MAG_W  = 9;
  localparam int unsigned PROD_W = 17;

  // quarter sine table, entries 0..90 degrees
  localparam int unsigned SINE_W       = SINE_FRAC_BITS + 1;
  localparam int unsigned QUARTER_DEG  = 90;
  localparam int unsigned SINE_ENTRIES = QUARTER_DEG + 1;
  localparam int unsigned SINE_IDX_W   = $clog2(SINE_ENTRIES);

  // drive scaling: p = prod * 255 / 256 / 100, the divide by 100 done as
  // a reciprocal multiply that is exact for every operand below 2^17
  localparam int unsigned SCALE_DIV   = 100;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + SCALE_DIV - 1) / SCALE_DIV);

  localparam logic [DUTY_W-1:0] DUTY_MAX  = '1;
  localparam logic [DUTY_W-1:0] DUTY_IDLE = DUTY_W'(1);

  localparam logic [WHEEL_COUNT-1:0][CFG_W-1:0] ANGLE_RESET =
    {9'd315, 9'd225, 9'd135, 9'd45};
  localparam logic [CFG_W-1:0] GAIN_RESET = 9'd256;

  typedef enum logic [KIND_W-1:0] {
    KIND_DIRECTION = 2'd0,
    KIND_LOAD      = 2'd1,
    KIND_EMIT      = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_W1_ANGLE = 3'd0,
    CFG_W2_ANGLE = 3'd1,
    CFG_W3_ANGLE = 3'd2,
    CFG_W4_ANGLE = 3'd3,
    CFG_W1_GAIN  = 3'd4,
    CFG_W2_GAIN  = 3'd5,
    CFG_W3_GAIN  = 3'd6,
    CFG_W4_GAIN  = 3'd7
  } cfg_reg_e;

  // one wheel's request into the drive stage
  typedef struct packed {
    logic              pos;   // stored speed strictly positive
    logic [PROD_W-1:0] prod;  // |speed| * gain
  } drive_req_t;

  typedef logic [SINE_ENTRIES-1:0][SINE_W-1:0] sine_tab_t;

  // fixed-point series for round(sin(d deg) * 2^SINE_FRAC_BITS), d = 0..90
  localparam int unsigned      CALC_BITS = 30;
  localparam logic [63:0]      PI_Q60    = 64'h3243F6A8885A308D;

  function automatic sine_tab_t build_sine_table();
    sine_tab_t   tab;
    logic [63:0] step;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned sh;
    sh   = CALC_BITS - SINE_FRAC_BITS;
    step = PI_Q60 / 64'd180;
    for (int unsigned d = 0; d < SINE_ENTRIES; d++) begin
      x    = (64'(d) * step) >> CALC_BITS;
      sum  = x;
      term = x;
      for (int unsigned k = 1; k <= 7; k++) begin
        term = (term * x) >> CALC_BITS;
        term = ((term * x) >> CALC_BITS) / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      tab[d] = SINE_W'((sum + (64'd1 << (sh - 1))) >> sh);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

>>> hdl/owdm_kinematics.sv
// owdm_kinematics: speed of one wheel from travel direction, speed and rotation.
// Depends on owdm_pkg (sine table, widths).
`timescale 1ns / 1ps

module owdm_kinematics (
  input  logic        [owdm_pkg::CFG_W-1:0]   angle_i,
  input  logic signed [owdm_pkg::DIR_W-1:0]   direction_i,
  input  logic signed [owdm_pkg::PCT_W-1:0]   speed_i,
  input  logic signed [owdm_pkg::PCT_W-1:0]   rotation_i,
  output logic signed [owdm_pkg::SPEED_W-1:0] wheel_speed_o
);
  import owdm_pkg::*;

  localparam int unsigned DIFF_W = 12;
  localparam int unsigned RED_W  = 11;
  localparam int unsigned DEG_W  = 9;
  localparam int unsigned PRODS_W = SINE_W + PCT_W;
  localparam int unsigned Q_W     = PRODS_W - SINE_FRAC_BITS;

  logic signed [DIFF_W-1:0]  diff;
  logic        [RED_W-1:0]   red0, red1, red2, red3;
  logic        [DEG_W-1:0]   deg;
  logic        [SINE_IDX_W-1:0] idx;
  logic                      sine_neg;
  logic        [SINE_W-1:0]  sine_mag;
  logic        [PCT_W-1:0]   speed_abs;
  logic        [PRODS_W-1:0] prod;
  logic        [Q_W-1:0]     q;
  logic signed [SPEED_W-1:0] q_s;

  // bias by four turns so the difference is never negative, then peel off
  // 1440, 720 and 360 to land in 0..359
  always_comb begin
    diff = DIFF_W'(direction_i) + DIFF_W'(1440) - $signed({3'b000, angle_i});
    red0 = diff[RED_W-1:0];
    red1 = (red0 >= RED_W'(1440)) ? red0 - RED_W'(1440) : red0;
    red2 = (red1 >= RED_W'(720))  ? red1 - RED_W'(720)  : red1;
    red3 = (red2 >= RED_W'(360))  ? red2 - RED_W'(360)  : red2;
    deg  = red3[DEG_W-1:0];
  end

  // fold the full circle onto the quarter table
  always_comb begin
    if (deg <= DEG_W'(90)) begin
      idx      = SINE_IDX_W'(deg);
      sine_neg = 1'b0;
    end else if (deg <= DEG_W'(180)) begin
      idx      = SINE_IDX_W'(DEG_W'(180) - deg);
      sine_neg = 1'b0;
    end else if (deg <= DEG_W'(270)) begin
      idx      = SINE_IDX_W'(deg - DEG_W'(180));
      sine_neg = 1'b1;
    end else begin
      idx      = SINE_IDX_W'(DEG_W'(360) - deg);
      sine_neg = 1'b1;
    end
  end

  always_comb begin
    sine_mag  = SINE_TABLE[idx];
    speed_abs = speed_i[PCT_W-1] ? PCT_W'(-speed_i) : PCT_W'(speed_i);
    prod      = PRODS_W'(sine_mag) * PRODS_W'(speed_abs);
    q         = prod[PRODS_W-1:SINE_FRAC_BITS];
    // magnitude truncated, sign applied afterwards: rounds toward zero
    q_s       = (sine_neg ^ speed_i[PCT_W-1]) ? -$signed(SPEED_W'(q))
                                              : $signed(SPEED_W'(q));
    wheel_speed_o = q_s + SPEED_W'(rotation_i);
  end

endmodule

>>> hdl/owdm_drive.sv
// owdm_drive: half-bridge duty pair of one wheel from |speed| * gain.
// Depends on owdm_pkg (drive_req_t, scaling constants).
`timescale 1ns / 1ps

module owdm_drive (
  input  owdm_pkg::drive_req_t              req_i,
  output logic [owdm_pkg::DUTY_W-1:0]       side_a_o,
  output logic [owdm_pkg::DUTY_W-1:0]       side_b_o
);
  import owdm_pkg::*;

  localparam int unsigned Y_W  = PROD_W + 8;
  localparam int unsigned QM_W = PROD_W + RECIP_W;
  localparam int unsigned P_W  = QM_W - RECIP_SHIFT;

  logic [Y_W-1:0]    y;
  logic [PROD_W-1:0] v;
  logic [QM_W-1:0]   qm;
  logic [P_W-1:0]    p;
  logic [DUTY_W-1:0] duty;

  always_comb begin
    // times 255 by shift and subtract, then /256 and /100
    y    = {req_i.prod, 8'h00} - Y_W'(req_i.prod);
    v    = y[Y_W-1:8];
    qm   = QM_W'(v) * QM_W'(RECIP_MUL);
    p    = qm[QM_W-1:RECIP_SHIFT];
    duty = (p > P_W'(DUTY_MAX)) ? DUTY_MAX : p[DUTY_W-1:0];
    if (req_i.pos && (p != '0)) begin
      side_a_o = DUTY_IDLE;
      side_b_o = duty;
    end else begin
      side_a_o = duty;
      side_b_o = DUTY_IDLE;
    end
  end

endmodule

>>> hdl/omni_wheel_drive_mixer.sv
// omni_wheel_drive_mixer: four wheel omni drive kinematics with duty outputs.
// Depends on owdm_pkg, owdm_kinematics and owdm_drive.
// Path: an emit request passes the input register, drive register and output
// register before it shows tvalid.
// Throughput: one request per cycle; stages advance independently, bounded
// only by downstream tready through the output register.
// Reset: asynchronous, active low; speeds clear to zero, angles 45/135/225/315,
// gains 1.0, all stages empty.
`timescale 1ns / 1ps

module omni_wheel_drive_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [owdm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [owdm_pkg::CFG_W-1:0]        cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // direction[9:0] speed[17:10] rotation[25:18] wheel1_set[34:26]
  // wheel2_set[43:35] wheel3_set[52:44] wheel4_set[61:53] zero[63:62]
  input  logic [63:0] s_axis_tdata_i,
  // kind[1:0]
  input  logic [owdm_pkg::KIND_W-1:0] s_axis_tuser_i,
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // wheel1_side_a[7:0] wheel1_side_b[15:8] wheel2_side_a[23:16]
  // wheel2_side_b[31:24] wheel3_side_a[39:32] wheel3_side_b[47:40]
  // wheel4_side_a[55:48] wheel4_side_b[63:56]
  output logic [63:0] m_axis_tdata_o
);
  import owdm_pkg::*;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [CFG_W-1:0] angle_q [WHEEL_COUNT];
  logic [CFG_W-1:0] gain_q  [WHEEL_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        angle_q[w] <= ANGLE_RESET[w];
        gain_q[w]  <= GAIN_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_W1_ANGLE: angle_q[0] <= cfg_data_i;
        CFG_W2_ANGLE: angle_q[1] <= cfg_data_i;
        CFG_W3_ANGLE: angle_q[2] <= cfg_data_i;
        CFG_W4_ANGLE: angle_q[3] <= cfg_data_i;
        CFG_W1_GAIN:  gain_q[0]  <= cfg_data_i;
        CFG_W2_GAIN:  gain_q[1]  <= cfg_data_i;
        CFG_W3_GAIN:  gain_q[2]  <= cfg_data_i;
        CFG_W4_GAIN:  gain_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // stage handshake: each stage loads when empty or draining
  // ---------------------------------------------------------------
  logic in_v_q, mid_v_q, out_v_q;
  logic out_free, mid_free, in_free, a_fire;

  assign out_free = !out_v_q || m_axis_tready_i;
  assign mid_free = !mid_v_q || out_free;
  assign in_free  = !in_v_q  || mid_free;
  assign a_fire   = in_v_q && mid_free;

  assign s_axis_tready_o = in_free;
  assign m_axis_tvalid_o = out_v_q;

  // ---------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------
  logic [KIND_W-1:0]       kind_q;
  logic signed [DIR_W-1:0] dir_q;
  logic signed [PCT_W-1:0] spd_q;
  logic signed [PCT_W-1:0] rot_q;
  logic signed [SET_W-1:0] set_q [WHEEL_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_free) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && s_axis_tvalid_i) begin
      kind_q <= s_axis_tuser_i;
      dir_q  <= s_axis_tdata_i[9:0];
      spd_q  <= s_axis_tdata_i[17:10];
      rot_q  <= s_axis_tdata_i[25:18];
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        set_q[w] <= s_axis_tdata_i[26 + SET_W * w +: SET_W];
      end
    end
  end

  // ---------------------------------------------------------------
  // stage a: kinematics / direct load into the speed state, or
  // |speed| * gain for an emit request
  // ---------------------------------------------------------------
  logic signed [SPEED_W-1:0] speed_q   [WHEEL_COUNT];
  logic signed [SPEED_W-1:0] kin_speed [WHEEL_COUNT];
  logic        [MAG_W-1:0]   speed_abs [WHEEL_COUNT];
  drive_req_t                drive_d   [WHEEL_COUNT];
  drive_req_t                drive_q   [WHEEL_COUNT];
  logic [DUTY_W-1:0]         side_a    [WHEEL_COUNT];
  logic [DUTY_W-1:0]         side_b    [WHEEL_COUNT];
  logic [DUTY_W-1:0]         side_a_q  [WHEEL_COUNT];
  logic [DUTY_W-1:0]         side_b_q  [WHEEL_COUNT];

  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_wheel
    owdm_kinematics u_kin (
      .angle_i       (angle_q[w]),
      .direction_i   (dir_q),
      .speed_i       (spd_q),
      .rotation_i    (rot_q),
      .wheel_speed_o (kin_speed[w])
    );

    always_comb begin
      // stored speed stays in -256..255, so its magnitude reaches 256: 9 bits
      speed_abs[w]    = speed_q[w][SPEED_W-1] ? MAG_W'(-speed_q[w])
                                              : MAG_W'(speed_q[w]);
      drive_d[w].pos  = !speed_q[w][SPEED_W-1] && (speed_q[w] != '0);
      drive_d[w].prod = PROD_W'(speed_abs[w]) * PROD_W'(gain_q[w]);
    end

    owdm_drive u_drive (
      .req_i    (drive_q[w]),
      .side_a_o (side_a[w]),
      .side_b_o (side_b[w])
    );
  end

  // wheel speed state; a stop command falls out of the kinematics as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        speed_q[w] <= '0;
      end
    end else if (a_fire) begin
      case (kind_q)
        KIND_DIRECTION: begin
          for (int w = 0; w < WHEEL_COUNT; w++) begin
            speed_q[w] <= kin_speed[w];
          end
        end
        KIND_LOAD: begin
          for (int w = 0; w < WHEEL_COUNT; w++) begin
            speed_q[w] <= SPEED_W'(set_q[w]);
          end
        end
        default: ;
      endcase
    end
  end

  // only emit requests travel on past stage a
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
    end else if (mid_free) begin
      mid_v_q <= a_fire && (kind_q == KIND_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_free) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        drive_q[w] <= drive_d[w];
      end
    end
  end

  // ---------------------------------------------------------------
  // stage b: scaling and duty split into the output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= mid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && mid_v_q) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        side_a_q[w] <= side_a[w];
        side_b_q[w] <= side_b[w];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WHEEL_COUNT; w++) begin
      m_axis_tdata_o[2 * DUTY_W * w +: DUTY_W]          = side_a_q[w];
      m_axis_tdata_o[2 * DUTY_W * w + DUTY_W +: DUTY_W] = side_b_q[w];
    end
  end

endmodule

>>> hdl/owdm_checker.sv
// owdm_checker: port-level assertions for omni_wheel_drive_mixer, bound to it.
// Depends on owdm_pkg (duty constants).
`timescale 1ns / 1ps

module owdm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o
);
  import owdm_pkg::*;

  logic [WHEEL_COUNT-1:0] one_side_idle;

  always_comb begin
    for (int w = 0; w < WHEEL_COUNT; w++) begin
      one_side_idle[w] =
        (m_axis_tdata_o[2 * DUTY_W * w +: DUTY_W] == DUTY_IDLE) ||
        (m_axis_tdata_o[2 * DUTY_W * w + DUTY_W +: DUTY_W] == DUTY_IDLE);
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // every wheel keeps one half-bridge input at the idle duty
  a_duty_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (one_side_idle == '1))
    else $error("both half-bridge duties active");

  // an empty output register never back-pressures the request side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("request side stalled with output empty");

  // no result right out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid at reset release");

  // ready is never unknown while a request handshake takes place
  a_req_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> !$isunknown(s_axis_tready_o))
    else $error("request handshake unknown");

endmodule

bind omni_wheel_drive_mixer owdm_checker u_owdm_checker (.*);
